FILE: hdl/plfa_pkg.sv
// shared types, constants and table functions of the power-law force attenuation block
package plfa_pkg;

  // fraction bits of the internal base-2 logarithm
  localparam int LOG_FRAC = 24;
  // integer bits of the logarithm, signed
  localparam int LOG_INT_W = 6;
  localparam int LOG_W = LOG_INT_W + LOG_FRAC;
  // Q1.30 mantissa width
  localparam int MANT_W = 31;
  localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
  localparam logic [MANT_W-1:0] Q30_ONE = MANT_W'(1) << 30;
  // lanes of the log unit: thickness, density, force, gain
  localparam int NUM_LANES = 4;
  localparam int LANE_THICK = 0;
  localparam int LANE_DENS = 1;
  localparam int LANE_FORCE = 2;
  localparam int LANE_GAIN = 3;

  // register index codes
  typedef enum logic [2:0] {
    REG_GAIN_C,
    REG_THICK_EXP,
    REG_DENS_EXP,
    REG_FORCE_EXP,
    REG_LOADED
  } plfa_reg_e;

  // per-item control carried through the log unit
  typedef struct packed {
    logic [31:0] force_in;
    logic        use_pl;
    logic        in_valid;
    logic        gain_zero;
  } plfa_side_t;

  // per-item control carried through the exp unit
  typedef struct packed {
    plfa_side_t        base;
    logic              ovf;
    logic              unf;
    logic signed [5:0] shift_k;
  } plfa_tail_t;

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = val;
    res = '0;
    b = 64'h1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != '0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-(idx+1)) in Q1.30, by repeated truncated square roots of 2.0
  function automatic logic [MANT_W-1:0] exp_tab_entry(int idx);
    logic [63:0] v;
    v = 64'h8000_0000;
    for (int i = 0; i < LOG_FRAC; i++) begin
      if (i <= idx) v = isqrt64(v << 30);
    end
    return v[MANT_W-1:0];
  endfunction

endpackage

FILE: hdl/plfa_if.sv
// request and result channel interfaces
interface plfa_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_in;
  logic signed [31:0] layer_thickness;
  logic signed [31:0] layer_density;
  modport source(output valid, force_in, layer_thickness, layer_density, input ready);
  modport sink(input valid, force_in, layer_thickness, layer_density, output ready);
endinterface

interface plfa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_out;
  logic               input_valid;
  logic               saturated;
  modport source(output valid, force_out, input_valid, saturated, input ready);
  modport sink(input valid, force_out, input_valid, saturated, output ready);
endinterface

FILE: hdl/plfa_log2.sv
// pipelined base-2 logarithm over four lanes, one squaring per stage after the normalize stage
module plfa_log2 import plfa_pkg::*; #(
  parameter int VFB = 16,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [31:0]             x_i [NUM_LANES],
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [LOG_W-1:0] lg_o [NUM_LANES],
  output logic [SIDE_W-1:0]       side_o
);

  localparam int NS = LOG_FRAC + 1;

  logic [NS-1:0]         valid_q, valid_d, vin;
  logic [NS:0]           rdy;
  logic [MANT_W-1:0]     mant_q [NS][NUM_LANES];
  logic [MANT_W-1:0]     mant_d [NS][NUM_LANES];
  logic [4:0]            msb_q [NS][NUM_LANES];
  logic [4:0]            msb_d [NS][NUM_LANES];
  logic [LOG_FRAC-1:0]   frac_q [NS][NUM_LANES];
  logic [LOG_FRAC-1:0]   frac_d [NS][NUM_LANES];
  logic [SIDE_W-1:0]     side_q [NS];

  // stage advances when empty or when the next one moves
  assign rdy[NS] = out_ready_i;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !valid_q[s] || rdy[s+1];
  end
  assign in_ready_o = rdy[0];
  assign vin = {valid_q[NS-2:0], in_valid_i};
  assign valid_d = (rdy[NS-1:0] & vin) | (~rdy[NS-1:0] & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // normalize to a Q1.30 mantissa
  always_comb begin
    logic [31:0] sh;
    for (int l = 0; l < NUM_LANES; l++) begin
      msb_d[0][l] = '0;
      for (int b = 0; b < 32; b++) begin
        if (x_i[l][b]) msb_d[0][l] = 5'(b);
      end
      sh = x_i[l] << (5'd30 - msb_d[0][l]);
      if (msb_d[0][l] == 5'd31) begin
        mant_d[0][l] = x_i[l][31:1];
      end else begin
        mant_d[0][l] = sh[MANT_W-1:0];
      end
      frac_d[0][l] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mant_q[0] <= mant_d[0];
      msb_q[0]  <= msb_d[0];
      frac_q[0] <= frac_d[0];
      side_q[0] <= side_i;
    end
  end

  // one fraction bit per stage by squaring
  for (genvar s = 1; s < NS; s++) begin : g_sq
    always_comb begin
      logic [61:0] sq;
      logic [31:0] t;
      for (int l = 0; l < NUM_LANES; l++) begin
        sq = 62'(mant_q[s-1][l]) * 62'(mant_q[s-1][l]);
        t = sq[61:30];
        msb_d[s][l] = msb_q[s-1][l];
        if (t[31]) begin
          mant_d[s][l] = t[31:1];
          frac_d[s][l] = {frac_q[s-1][l][LOG_FRAC-2:0], 1'b1};
        end else begin
          mant_d[s][l] = t[MANT_W-1:0];
          frac_d[s][l] = {frac_q[s-1][l][LOG_FRAC-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        mant_q[s] <= mant_d[s];
        msb_q[s]  <= msb_d[s];
        frac_q[s] <= frac_d[s];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // integer part is the msb position less the value fraction bits
  always_comb begin
    logic [LOG_INT_W-1:0] ip;
    for (int l = 0; l < NUM_LANES; l++) begin
      ip = LOG_INT_W'(msb_q[NS-1][l]) - LOG_INT_W'(VFB);
      lg_o[l] = $signed({ip, frac_q[NS-1][l]});
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

FILE: hdl/plfa_exp2.sv
// pipelined 2^f for a 24 bit fraction, one table multiply per stage
module plfa_exp2 import plfa_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [LOG_FRAC-1:0] frac_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MANT_W-1:0]   mant_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int NS = LOG_FRAC;

  logic [NS-1:0]       valid_q, valid_d, vin;
  logic [NS:0]         rdy;
  logic [MANT_W-1:0]   mant_q [NS];
  logic [MANT_W-1:0]   mant_d [NS];
  logic [LOG_FRAC-1:0] frac_q [NS];
  logic [SIDE_W-1:0]   side_q [NS];

  // stage advances when empty or when the next one moves
  assign rdy[NS] = out_ready_i;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !valid_q[s] || rdy[s+1];
  end
  assign in_ready_o = rdy[0];
  assign vin = {valid_q[NS-2:0], in_valid_i};
  assign valid_d = (rdy[NS-1:0] & vin) | (~rdy[NS-1:0] & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_mul
    localparam logic [MANT_W-1:0] TAB = exp_tab_entry(s);
    logic [MANT_W-1:0]   m_in;
    logic [LOG_FRAC-1:0] f_in;
    logic [SIDE_W-1:0]   sd_in;

    if (s == 0) begin : g_first
      assign m_in = Q30_ONE;
      assign f_in = frac_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign m_in = mant_q[s-1];
      assign f_in = frac_q[s-1];
      assign sd_in = side_q[s-1];
    end

    // multiply by the table root when this fraction bit is set, round, clamp
    always_comb begin
      logic [61:0] prod;
      prod = 62'(m_in) * 62'(TAB) + (62'(1) << 29);
      if (!f_in[LOG_FRAC-1-s]) begin
        mant_d[s] = m_in;
      end else if (prod[61]) begin
        mant_d[s] = MANT_MAX;
      end else begin
        mant_d[s] = prod[60:30];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        mant_q[s] <= mant_d[s];
        frac_q[s] <= f_in;
        side_q[s] <= sd_in;
      end
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign mant_o = mant_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

FILE: hdl/power_law_force_attenuation.sv
// power-law force attenuation, pipelined from request to result
// throughput one request per cycle; stalls hold every stage without loss
// 25 log stages (normalize plus 24 squarings), term, sum, 24 exp stages, output
// per-stage valid bits let bubbles close up behind a stalled result
// reset clears valid bits and loads the register defaults, power law off
module power_law_force_attenuation import plfa_pkg::*; #(
  parameter int VALUE_FRAC_BITS = 16,
  parameter int EXPONENT_FRAC_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  plfa_req_if.sink     req_i,
  plfa_rsp_if.source   rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SIDE_W = $bits(plfa_side_t);
  localparam int TAIL_W = $bits(plfa_tail_t);
  localparam logic signed [61:0] HALF = 62'(1) <<< (EXPONENT_FRAC_BITS - 1);
  localparam logic signed [65:0] BIAS = 66'(VALUE_FRAC_BITS) <<< LOG_FRAC;

  // configuration registers
  logic [31:0]        gain_c_q;
  logic signed [31:0] thick_exp_q, dens_exp_q, force_exp_q;
  logic               loaded_q;
  logic               wr_en;
  plfa_reg_e          reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_sel = plfa_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_c_q    <= 32'h0001_0000;
      thick_exp_q <= 32'sh0100_0000;
      dens_exp_q  <= 32'sh0100_0000;
      force_exp_q <= 32'sh0100_0000;
      loaded_q    <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GAIN_C:    gain_c_q <= pwdata;
        REG_THICK_EXP: thick_exp_q <= pwdata;
        REG_DENS_EXP:  dens_exp_q <= pwdata;
        REG_FORCE_EXP: force_exp_q <= pwdata;
        REG_LOADED:    loaded_q <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_GAIN_C:    prdata = gain_c_q;
      REG_THICK_EXP: prdata = thick_exp_q;
      REG_DENS_EXP:  prdata = dens_exp_q;
      REG_FORCE_EXP: prdata = force_exp_q;
      REG_LOADED:    prdata = {31'b0, loaded_q};
      default:       prdata = '0;
    endcase
  end

  // entry: request checks and log unit operands
  plfa_side_t         side_in;
  logic [31:0]        log_x [NUM_LANES];
  logic               log_out_valid, log_out_ready;
  logic signed [LOG_W-1:0] log_lg [NUM_LANES];
  logic [SIDE_W-1:0]  log_side;

  always_comb begin
    side_in.force_in  = req_i.force_in;
    side_in.in_valid  = loaded_q && (req_i.force_in > 0) && (req_i.layer_thickness > 0);
    side_in.use_pl    = side_in.in_valid && (req_i.layer_density > 0);
    side_in.gain_zero = (gain_c_q == '0);
    log_x[LANE_THICK] = req_i.layer_thickness;
    log_x[LANE_DENS]  = req_i.layer_density;
    log_x[LANE_FORCE] = req_i.force_in;
    log_x[LANE_GAIN]  = gain_c_q;
  end

  plfa_log2 #(
    .VFB    (VALUE_FRAC_BITS),
    .SIDE_W (SIDE_W)
  ) u_log2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .x_i         (log_x),
    .side_i      (side_in),
    .out_valid_o (log_out_valid),
    .out_ready_i (log_out_ready),
    .lg_o        (log_lg),
    .side_o      (log_side)
  );

  // term stage: thickness, density and force logs times their exponents, rounded to the log format
  logic                    term_valid_q, term_rdy;
  logic signed [61:0]      term_q [3];
  logic signed [61:0]      term_d [3];
  logic signed [LOG_W-1:0] lg_gain_q;
  logic [SIDE_W-1:0]       term_side_q;

  always_comb begin
    logic signed [61:0] a, b;
    for (int l = 0; l < 3; l++) begin
      a = 62'(log_lg[l]);
      case (l)
        LANE_THICK: b = 62'(thick_exp_q);
        LANE_DENS:  b = 62'(dens_exp_q);
        default:    b = 62'(force_exp_q);
      endcase
      term_d[l] = (a * b + HALF) >>> EXPONENT_FRAC_BITS;
    end
  end

  // sum stage: total log, split into shift and fraction, with overflow and underflow flags
  logic               sum_valid_q, sum_rdy;
  plfa_tail_t         sum_tail_q, sum_tail_d;
  logic [LOG_FRAC-1:0] sum_frac_q, sum_frac_d;
  logic               exp_in_ready;

  always_comb begin
    logic signed [65:0] s;
    logic signed [65:0] k;
    s = 66'(term_q[0]) + 66'(term_q[1]) + 66'(term_q[2]) + 66'(lg_gain_q) + BIAS;
    k = s >>> LOG_FRAC;
    sum_tail_d.base    = plfa_side_t'(term_side_q);
    sum_tail_d.ovf     = (k >= 66'sd31);
    sum_tail_d.unf     = (k < -66'sd1);
    sum_tail_d.shift_k = k[5:0];
    sum_frac_d         = s[LOG_FRAC-1:0];
  end

  assign sum_rdy = !sum_valid_q || exp_in_ready;
  assign term_rdy = !term_valid_q || sum_rdy;
  assign log_out_ready = term_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      if (term_rdy) term_valid_q <= log_out_valid;
      if (sum_rdy) sum_valid_q <= term_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_rdy) begin
      term_q      <= term_d;
      lg_gain_q   <= log_lg[LANE_GAIN];
      term_side_q <= log_side;
    end
    if (sum_rdy) begin
      sum_tail_q <= sum_tail_d;
      sum_frac_q <= sum_frac_d;
    end
  end

  // exp unit
  logic              exp_out_valid, exp_out_ready;
  logic [MANT_W-1:0] exp_mant;
  logic [TAIL_W-1:0] exp_side;

  plfa_exp2 #(
    .SIDE_W (TAIL_W)
  ) u_exp2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid_q),
    .in_ready_o  (exp_in_ready),
    .frac_i      (sum_frac_q),
    .side_i      (sum_tail_q),
    .out_valid_o (exp_out_valid),
    .out_ready_i (exp_out_ready),
    .mant_o      (exp_mant),
    .side_o      (exp_side)
  );

  // output stage: final shift with rounding and the special cases
  plfa_tail_t         tail;
  logic               out_valid_q, out_rdy;
  logic signed [31:0] force_out_q, force_out_d;
  logic               input_valid_q, saturated_q, saturated_d;

  assign tail = plfa_tail_t'(exp_side);

  always_comb begin
    logic [4:0]  sh;
    logic [31:0] rnd;
    logic [31:0] raw;
    sh = 5'(6'sd30 - tail.shift_k);
    rnd = 32'(exp_mant) + ((sh == '0) ? 32'd0 : (32'd1 << (sh - 5'd1)));
    raw = rnd >> sh;
    saturated_d = 1'b0;
    if (!tail.base.use_pl) begin
      force_out_d = tail.base.force_in;
    end else if (tail.base.gain_zero) begin
      force_out_d = '0;
    end else if (tail.ovf) begin
      force_out_d = 32'sh7FFF_FFFF;
      saturated_d = 1'b1;
    end else if (tail.unf) begin
      force_out_d = '0;
    end else if (raw[31]) begin
      force_out_d = 32'sh7FFF_FFFF;
      saturated_d = 1'b1;
    end else begin
      force_out_d = raw;
    end
  end

  assign out_rdy = !out_valid_q || rsp_o.ready;
  assign exp_out_ready = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= exp_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      force_out_q   <= force_out_d;
      input_valid_q <= tail.base.in_valid;
      saturated_q   <= saturated_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.force_out   = force_out_q;
  assign rsp_o.input_valid = input_valid_q;
  assign rsp_o.saturated   = saturated_q;

endmodule
